>>> rtl/core/printer_escape_stream_filter_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the printer escape stream filter
// Immediate-consequence and next-cycle property checks on clk / rst.
// ---------------------------------------------------------------------------
`ifndef PRINTER_ESCAPE_STREAM_FILTER_TOP_MACROS_SVH
`define PRINTER_ESCAPE_STREAM_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Consequence holds in the same cycle as the antecedent.
`define PESF_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pesf check failed");
// Consequence holds in the cycle after the antecedent.
`define PESF_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pesf next-cycle check failed");
`else
`define PESF_CHECK(lbl, ante, cons)
`define PESF_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/pesf_pkg.sv
// ---------------------------------------------------------------------------
// pesf_pkg
// Types, codes and helpers shared by the printer escape stream filter.
// ---------------------------------------------------------------------------
package pesf_pkg;

  localparam int CHANNELS_DEF = 33;

  // parser codes
  localparam logic [2:0] PS_STD    = 3'd0;
  localparam logic [2:0] PS_ESC    = 3'd1;
  localparam logic [2:0] PS_LEN_LO = 3'd2;
  localparam logic [2:0] PS_LEN_HI = 3'd3;
  localparam logic [2:0] PS_RUN    = 3'd4;

  // status codes
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_RANGE  = 2'd1;
  localparam logic [1:0] STS_NOTPRN = 2'd2;

  // first printer channel
  localparam logic [5:0] PRN_FIRST = 6'd2;

  // character codes
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_EOF = 8'h1A;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_HOM = 8'h1C;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_T   = 8'h54;

  localparam logic [15:0] POS_HOME = 16'd1;

  // per-channel state word
  typedef struct packed {
    logic [2:0]  parse;
    logic [15:0] col;
    logic [15:0] line;
    logic [15:0] byp;
    logic        prt;
  } chan_state_t;

  // results caused by one item
  typedef struct packed {
    logic            bval;
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
    logic [15:0]     col;
    logic [15:0]     line;
    logic [1:0]      status;
  } result_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

>>> rtl/core/pesf_state_mem.sv
// ---------------------------------------------------------------------------
// pesf_state_mem
// Per-channel state memory: registered read, valid bits, write forwarding.
// ---------------------------------------------------------------------------
module pesf_state_mem
  import pesf_pkg::*;
#(
  parameter int DEPTH = CHANNELS_DEF,
  parameter int AW    = $clog2(CHANNELS_DEF)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [AW-1:0] rd_addr,
  input  logic        wr_en,
  input  logic [AW-1:0] wr_addr,
  input  chan_state_t wr_data,
  output chan_state_t rd_data
);

  chan_state_t      mem [DEPTH];
  chan_state_t      mem_q;
  logic [DEPTH-1:0] vld;
  logic             vld_q;
  logic             fwd;
  chan_state_t      fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q    <= mem[rd_addr];
    fwd_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
      fwd   <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      vld_q <= vld[rd_addr];
      fwd   <= wr_en && (wr_addr == rd_addr);
    end
  end

  // an unwritten entry reads as the reset state; the run counter has no reset
  always_comb begin
    if (fwd) begin
      rd_data = fwd_data;
    end else if (vld_q) begin
      rd_data = mem_q;
    end else begin
      rd_data       = mem_q;
      rd_data.parse = PS_STD;
      rd_data.col   = POS_HOME;
      rd_data.line  = POS_HOME;
      rd_data.prt   = 1'b0;
    end
  end

endmodule

>>> rtl/core/pesf_step.sv
// ---------------------------------------------------------------------------
// pesf_step
// Escape parser step: next channel state and the results of one item.
// ---------------------------------------------------------------------------
module pesf_step
  import pesf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic [5:0]  ch,
  input  logic [7:0]  c,
  input  logic        fail,
  input  chan_state_t cur,
  output chan_state_t nxt,
  output logic        wr,
  output result_t     res
);

  localparam logic [6:0] CH_LIM = 7'(CHANNELS);

  logic            above;
  logic            screen;
  logic [2:0]      nb;
  logic [3:0][7:0] bytes;
  logic            tail;
  logic [7:0]      cc;
  logic [15:0]     lenv;
  logic [15:0]     bdec;

  assign above  = {1'b0, ch} >= CH_LIM;
  assign screen = ch < PRN_FIRST;
  assign wr     = !above && !screen;
  assign lenv   = {c, cur.byp[7:0]};
  assign bdec   = cur.byp - 16'd1;

  always_comb begin
    nxt   = cur;
    nb    = 3'd0;
    bytes = '0;
    tail  = 1'b0;
    cc    = c;
    case (cur.parse)
      PS_ESC: begin
        nxt.parse = PS_STD;
        if (c == CH_T) begin
          nxt.parse = PS_LEN_LO;
        end else begin
          bytes[0] = CH_ESC;
          nb       = 3'd1;
          tail     = 1'b1;
        end
      end
      PS_LEN_LO: begin
        nxt.byp   = {8'd0, c};
        nxt.parse = PS_LEN_HI;
      end
      PS_LEN_HI: begin
        nxt.byp = lenv;
        if (lenv != 16'd0) begin
          bytes[0]  = CH_ESC;
          bytes[1]  = CH_T;
          bytes[2]  = lenv[7:0];
          nb        = 3'd3;
          nxt.parse = PS_RUN;
          tail      = 1'b1;
        end else begin
          nxt.parse = PS_STD;
        end
      end
      PS_RUN: begin
        bytes[0] = c;
        nb       = 3'd1;
        if (!fail) begin
          nxt.prt = 1'b1;
          nxt.byp = bdec;
          if (bdec == 16'd0) begin
            nxt.parse = PS_STD;
          end
        end
      end
      default: begin
        case (c)
          CH_BEL: begin
          end
          CH_FF, CH_HOM: begin
            nxt.prt  = 1'b1;
            bytes[0] = c;
            bytes[1] = CH_CR;
            nb       = 3'd2;
            nxt.col  = POS_HOME;
            nxt.line = POS_HOME;
          end
          CH_CR: begin
            nxt.col = POS_HOME;
            tail    = 1'b1;
          end
          CH_LF: begin
            nxt.prt  = 1'b1;
            bytes[0] = c;
            bytes[1] = CH_CR;
            nb       = 3'd2;
            nxt.line = sat_inc(cur.line);
            nxt.col  = POS_HOME;
          end
          CH_BS: begin
            nxt.col = (cur.col <= POS_HOME) ? POS_HOME : cur.col - 16'd1;
            tail    = 1'b1;
          end
          CH_ESC: begin
            nxt.parse = PS_ESC;
          end
          CH_EOF: begin
            if (cur.prt) begin
              bytes[0] = c;
              nb       = 3'd1;
              nxt.prt  = 1'b0;
            end
          end
          CH_ACK: begin
            cc      = CH_SP;
            nxt.col = sat_inc(cur.col);
            tail    = 1'b1;
          end
          default: begin
            nxt.col = sat_inc(cur.col);
            tail    = 1'b1;
          end
        endcase
      end
    endcase

    // append the (possibly translated) character itself
    if (tail) begin
      bytes[nb[1:0]] = cc;
      nb             = nb + 3'd1;
      if (!fail) begin
        nxt.prt = 1'b1;
      end
    end

    res.bval     = wr && (nb != 3'd0);
    res.last_idx = (wr && (nb != 3'd0)) ? 2'(nb - 3'd1) : 2'd0;
    res.bytes    = bytes;
    res.col      = wr ? nxt.col : 16'd0;
    res.line     = wr ? nxt.line : 16'd0;
    if (above) begin
      res.status = STS_RANGE;
    end else if (screen) begin
      res.status = STS_NOTPRN;
    end else begin
      res.status = STS_OK;
    end
  end

endmodule

>>> rtl/core/pesf_emit.sv
// ---------------------------------------------------------------------------
// pesf_emit
// Output register: holds one item's results and sends them one per cycle while out_ready is high.
// ---------------------------------------------------------------------------
module pesf_emit
  import pesf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load_valid,
  input  result_t     bundle,
  output logic        load_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        byte_valid,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic [15:0] column,
  output logic [15:0] line,
  output logic [1:0]  status
);

  result_t    q;
  logic       busy;
  logic [1:0] idx;
  logic       fire;
  logic       done;

  assign fire       = busy && out_ready;
  assign done       = fire && (idx == q.last_idx);
  assign load_ready = !busy || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load_valid && load_ready) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (fire) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      q <= bundle;
    end
  end

  assign out_valid  = busy;
  assign byte_valid = q.bval;
  assign out_byte   = q.bval ? q.bytes[idx] : 8'd0;
  assign last       = (idx == q.last_idx);
  assign column     = q.col;
  assign line       = q.line;
  assign status     = q.status;

endmodule

>>> rtl/core/printer_escape_stream_filter_top.sv
// ---------------------------------------------------------------------------
// printer_escape_stream_filter_top
// Per-channel printer escape filter: one byte in, one to four results out.
// ---------------------------------------------------------------------------
// Path: an accepted item waits in the step stage while its state word is
//   read, then moves to the output register once that register can take it.
// Throughput: one item per cycle while each item yields one result and the
//   receiver is ready; items with more results hold up the input until taken.
// Reset: synchronous; clears the per-channel valid bits at once, so every
//   channel reads as home, standard parser, nothing printed; no clearing pass.
`include "printer_escape_stream_filter_top_macros.svh"

module printer_escape_stream_filter_top
  import pesf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  channel,
  input  logic [7:0]  data_byte,
  input  logic        sink_fail,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        byte_valid,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic [15:0] column,
  output logic [15:0] line,
  output logic [1:0]  status
);

  localparam int         AW     = $clog2(CHANNELS);
  localparam logic [6:0] CH_LIM = 7'(CHANNELS);

  // item held in the step stage while its state word is read
  logic        s1_valid;
  logic [5:0]  s1_ch;
  logic [7:0]  s1_c;
  logic        s1_fail;

  logic        in_fire;
  logic        s1_adv;
  logic        load_ready;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic          step_wr;
  chan_state_t   cur_state;
  chan_state_t   nxt_state;
  result_t       step_res;

  // map a channel number to a memory row; out-of-range channels use row 0
  // and never write, so the read is simply discarded
  function automatic logic [AW-1:0] row_of(input logic [5:0] ch);
    return ({1'b0, ch} < CH_LIM) ? ch[AW-1:0] : '0;
  endfunction

  // advance the step stage whenever the output register can take its item
  assign s1_adv   = s1_valid && load_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch   <= channel;
      s1_c    <= data_byte;
      s1_fail <= sink_fail;
    end
  end

  // read the new item's row on acceptance; re-read the held row on a stall
  // so the registered read data stays current
  assign rd_addr = in_fire ? row_of(channel) : row_of(s1_ch);
  assign wr_addr = row_of(s1_ch);
  assign wr_en   = s1_adv && step_wr;

  pesf_state_mem #(
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (nxt_state),
    .rd_data (cur_state)
  );

  pesf_step #(
    .CHANNELS (CHANNELS)
  ) u_step (
    .ch   (s1_ch),
    .c    (s1_c),
    .fail (s1_fail),
    .cur  (cur_state),
    .nxt  (nxt_state),
    .wr   (step_wr),
    .res  (step_res)
  );

  pesf_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s1_valid),
    .bundle     (step_res),
    .load_ready (load_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte_valid (byte_valid),
    .out_byte   (out_byte),
    .last       (last),
    .column     (column),
    .line       (line),
    .status     (status)
  );

  // a bare position report is always the only result of its item
  `PESF_CHECK(a_report_single, out_valid && !byte_valid, last)
  // a rejected channel carries no byte and no position
  `PESF_CHECK(a_reject_empty, out_valid && status != STS_OK, !byte_valid && column == 16'd0 && line == 16'd0)
  // a printer position never drops below home
  `PESF_CHECK(a_pos_home, out_valid && status == STS_OK, column != 16'd0 && line != 16'd0)
  // a stalled step stage keeps its item
  `PESF_CHECK_NEXT(a_s1_hold, s1_valid && !load_ready, s1_valid && $stable(s1_ch) && $stable(s1_c) && $stable(s1_fail))

endmodule

>>> tb/tb_printer_escape_stream_filter_top.sv
// ---------------------------------------------------------------------------
// Testbench for printer_escape_stream_filter_top
// Sends bytes to printer, screen and out-of-range channels over a valid/ready
// input, predicts every result from a per-channel model of the escape
// parser, column, line, raw-run counter and printed flag, and checks each
// result field by field, with and without random idling on both sides.
// ---------------------------------------------------------------------------
module tb_printer_escape_stream_filter_top
  import pesf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH          = CHANNELS_DEF;
  localparam int SETTLE_CYC   = 16;     // well past the pipeline's latency
  localparam int STALL_LIMIT  = 5000;   // cycles with no handshake at all
  localparam int PHASE_ITEMS  = 70;     // printer items per random phase

  // One result as seen on the output ports.
  typedef struct packed {
    logic        bval;
    logic [7:0]  obyte;
    logic        fin;
    logic [15:0] col;
    logic [15:0] ln;
    logic [1:0]  sts;
  } prn_result_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    logic [5:0]  ch;
    logic [7:0]  d;
    logic        f;
    bit          typed;
    prn_result_t want;
  } step_row_t;

  localparam int NROWS = 23;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [5:0]  channel   = '0;
  logic [7:0]  data_byte = '0;
  logic        sink_fail = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        byte_valid;
  logic [7:0]  out_byte;
  logic        last;
  logic [15:0] column;
  logic [15:0] line;
  logic [1:0]  status;

  printer_escape_stream_filter_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .channel    (channel),
    .data_byte  (data_byte),
    .sink_fail  (sink_fail),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte_valid (byte_valid),
    .out_byte   (out_byte),
    .last       (last),
    .column     (column),
    .line       (line),
    .status     (status)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Per-channel copy of the printer state, advanced as items are accepted.
  logic [2:0]  chan_parse [NCH];
  logic [15:0] chan_col   [NCH];
  logic [15:0] chan_line  [NCH];
  logic [15:0] chan_byp   [NCH];
  logic        chan_prt   [NCH];

  prn_result_t pending_results [$];
  prn_result_t want_now;
  step_row_t   steps [NROWS];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int items_sent    = 0;
  int printer_items = 0;
  int results_seen  = 0;
  int idle_cycles   = 0;

  // Print one line per mismatch and count it.
  task automatic note_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Advance the channel state for one accepted item and, when keep is set,
  // queue the printer bytes (or bare position report) that it should cause.
  task automatic filter_predict(input logic [5:0] ch, input logic [7:0] c_in,
                                input logic fail, input bit keep);
    logic [7:0]  emitted [4];
    logic [7:0]  c;
    logic        tail;
    int          n;
    prn_result_t r;
    c    = c_in;
    tail = 1'b0;
    n    = 0;
    // Screen, memory and out-of-range channels report status only.
    if (ch >= NCH || ch < PRN_FIRST) begin
      r = '{1'b0, 8'h00, 1'b1, 16'd0, 16'd0, (ch >= NCH) ? STS_RANGE : STS_NOTPRN};
      if (keep) pending_results.push_back(r);
      return;
    end
    case (chan_parse[ch])
      PS_ESC: begin
        // ESC T opens a length; anything else goes out behind ESC untouched
        chan_parse[ch] = PS_STD;
        if (c == CH_T) begin
          chan_parse[ch] = PS_LEN_LO;
        end else begin
          emitted[n] = CH_ESC; n++;
          tail = 1'b1;
        end
      end
      PS_LEN_LO: begin
        chan_byp[ch]   = {8'h00, c};
        chan_parse[ch] = PS_LEN_HI;
      end
      PS_LEN_HI: begin
        chan_byp[ch] = chan_byp[ch] + {c, 8'h00};
        if (chan_byp[ch] != 16'd0) begin
          emitted[0] = CH_ESC;
          emitted[1] = CH_T;
          emitted[2] = chan_byp[ch][7:0];
          n = 3;
          chan_parse[ch] = PS_RUN;
          tail = 1'b1;
        end else begin
          chan_parse[ch] = PS_STD;
        end
      end
      PS_RUN: begin
        // a failed write neither counts down nor marks the spool printed
        emitted[n] = c; n++;
        if (!fail) begin
          chan_prt[ch] = 1'b1;
          chan_byp[ch] = chan_byp[ch] - 16'd1;
          if (chan_byp[ch] == 16'd0) chan_parse[ch] = PS_STD;
        end
      end
      default: begin
        case (c)
          CH_BEL: ;
          CH_FF, CH_HOM: begin
            chan_prt[ch] = 1'b1;
            emitted[0] = c;
            emitted[1] = CH_CR;
            n = 2;
            chan_col[ch]  = POS_HOME;
            chan_line[ch] = POS_HOME;
          end
          CH_CR: begin
            chan_col[ch] = POS_HOME;
            tail = 1'b1;
          end
          CH_LF: begin
            chan_prt[ch] = 1'b1;
            emitted[0] = c;
            emitted[1] = CH_CR;
            n = 2;
            if (chan_line[ch] != 16'hFFFF) chan_line[ch]++;
            chan_col[ch] = POS_HOME;
          end
          CH_BS: begin
            if (chan_col[ch] > POS_HOME) chan_col[ch]--;
            tail = 1'b1;
          end
          CH_ESC: chan_parse[ch] = PS_ESC;
          CH_EOF: begin
            // close the spool only when something went out since last close
            if (chan_prt[ch]) begin
              emitted[n] = c; n++;
              chan_prt[ch] = 1'b0;
            end
          end
          default: begin
            if (c == CH_ACK) c = CH_SP;
            if (chan_col[ch] != 16'hFFFF) chan_col[ch]++;
            tail = 1'b1;
          end
        endcase
      end
    endcase
    if (tail) begin
      emitted[n] = c; n++;
      if (!fail) chan_prt[ch] = 1'b1;
    end
    if (!keep) return;
    if (n == 0) begin
      r = '{1'b0, 8'h00, 1'b1, chan_col[ch], chan_line[ch], STS_OK};
      pending_results.push_back(r);
    end else begin
      for (int k = 0; k < n; k++) begin
        r = '{1'b1, emitted[k], (k == n - 1), chan_col[ch], chan_line[ch], STS_OK};
        pending_results.push_back(r);
      end
    end
  endtask

  // Offer one item, idling first at the current rate; hold valid and the
  // payload until accepted, then advance the prediction. A typed row pushes
  // its own expectation in place of the predicted one.
  task automatic send_byte(input logic [5:0] ch, input logic [7:0] d, input logic f,
                           input bit typed, input prn_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    channel   <= ch;
    data_byte <= d;
    sink_fail <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (ch >= PRN_FIRST && ch < NCH) printer_items++;
    filter_predict(ch, d, f, !typed);
    if (typed) pending_results.push_back(want);
  endtask

  // Hold the sender until every expected result has come, then let the
  // pipeline settle.
  task automatic wait_for_drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Mostly a small pool of printer channels so that state builds up.
  function automatic logic [5:0] pick_printer();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      case ($urandom_range(4))
        0: return 6'd2;
        1: return 6'd3;
        2: return 6'd4;
        3: return 6'(NCH - 2);
        default: return 6'(NCH - 1);
      endcase
    end
    return 6'($urandom_range(NCH - 1, 2));
  endfunction

  function automatic logic [5:0] pick_other();
    if ($urandom_range(1)) return 6'($urandom_range(1));
    return 6'($urandom_range(63, NCH));
  endfunction

  function automatic logic [7:0] pick_control();
    case ($urandom_range(7))
      0: return CH_BEL;
      1: return CH_FF;
      2: return CH_HOM;
      3: return CH_CR;
      4: return CH_LF;
      5: return CH_BS;
      6: return CH_EOF;
      default: return CH_ACK;
    endcase
  endfunction

  // Random sequences on printer channels until goal printer items are in:
  // plain bytes, control codes, escape pairs and well-formed raw runs, with
  // noise on non-printer channels mixed in.
  task automatic play_random(input int goal);
    logic [5:0] ch;
    int         kind;
    int         len;
    int         guard;
    while (printer_items < goal) begin
      kind = $urandom_range(99);
      ch   = pick_printer();
      if (kind < 10) begin
        send_byte(pick_other(), 8'($urandom), 1'($urandom), 1'b0, '0);
      end else if (kind < 35 || (kind >= 65 && chan_parse[ch] != PS_STD)) begin
        send_byte(ch, 8'($urandom), ($urandom_range(7) == 0), 1'b0, '0);
      end else if (kind < 55) begin
        send_byte(ch, pick_control(), ($urandom_range(5) == 0), 1'b0, '0);
      end else if (kind < 65) begin
        // escape pair; keep T out so no length is opened by accident
        send_byte(ch, CH_ESC, 1'($urandom), 1'b0, '0);
        len = $urandom_range(255);
        if (len == CH_T || $urandom_range(7) == 0) len = CH_ESC;
        send_byte(ch, 8'(len), ($urandom_range(3) == 0), 1'b0, '0);
      end else begin
        // raw run: mostly short, sometimes empty or a little longer
        case ($urandom_range(19))
          0: len = 0;
          1: len = $urandom_range(20, 7);
          default: len = $urandom_range(6, 1);
        endcase
        send_byte(ch, CH_ESC, 1'b0, 1'b0, '0);
        send_byte(ch, CH_T, 1'($urandom), 1'b0, '0);
        send_byte(ch, len[7:0], 1'($urandom), 1'b0, '0);
        send_byte(ch, len[15:8], 1'($urandom), 1'b0, '0);
        guard = 0;
        while (chan_parse[ch] == PS_RUN && guard < 600) begin
          if ($urandom_range(5) == 0)
            send_byte(pick_other(), 8'($urandom), 1'($urandom), 1'b0, '0);
          send_byte(ch, 8'($urandom), ($urandom_range(5) == 0), 1'b0, '0);
          guard++;
        end
      end
    end
  endtask

  // Receiver: drop ready at the current idle rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected (byte %02h)", out_byte));
      end else begin
        want_now = pending_results.pop_front();
        if (byte_valid !== want_now.bval)
          note_mismatch($sformatf("byte_valid %b, want %b", byte_valid, want_now.bval));
        if (out_byte !== want_now.obyte)
          note_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want_now.obyte));
        if (last !== want_now.fin)
          note_mismatch($sformatf("last %b, want %b", last, want_now.fin));
        if (column !== want_now.col)
          note_mismatch($sformatf("column %0d, want %0d", column, want_now.col));
        if (line !== want_now.ln)
          note_mismatch($sformatf("line %0d, want %0d", line, want_now.ln));
        if (status !== want_now.sts)
          note_mismatch($sformatf("status %0d, want %0d", status, want_now.sts));
      end
    end
  end

  // Watchdog: end the run if no handshake happens for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NCH; i++) begin
      chan_parse[i] = PS_STD;
      chan_col[i]   = POS_HOME;
      chan_line[i]  = POS_HOME;
      chan_byp[i]   = 16'd0;
      chan_prt[i]   = 1'b0;
    end

    // Directed table. Typed rows carry results that follow straight from
    // reset or from the channel range; the rest go through the predictor.
    steps = '{
      // BEL on a fresh printer: bare position report at home
      '{6'd2,  CH_BEL, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, 16'd1, 16'd1, STS_OK}},
      // top channel and first channel past the printers
      '{6'd63, 8'h41,  1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, 16'd0, 16'd0, STS_RANGE}},
      '{6'(NCH), 8'hFF, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 16'd0, 16'd0, STS_RANGE}},
      // screen and memory channels
      '{6'd0,  8'h00,  1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 16'd0, 16'd0, STS_NOTPRN}},
      '{6'd1,  8'h41,  1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, 16'd0, 16'd0, STS_NOTPRN}},
      // last printer, top byte value
      '{6'(NCH - 1), 8'hFF, 1'b0, 1'b1, '{1'b1, 8'hFF, 1'b1, 16'd2, 16'd1, STS_OK}},
      // end of file with nothing printed yet
      '{6'd2,  CH_EOF, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, 16'd1, 16'd1, STS_OK}},
      '{6'd2,  8'h41,  1'b1, 1'b0, '0},   // sink error: flag stays clear
      '{6'd2,  CH_EOF, 1'b0, 1'b0, '0},   // so end of file is still dropped
      '{6'd2,  CH_ACK, 1'b0, 1'b0, '0},
      '{6'd2,  CH_BS,  1'b0, 1'b0, '0},
      '{6'd2,  CH_CR,  1'b0, 1'b0, '0},
      '{6'd2,  CH_BS,  1'b0, 1'b0, '0},   // clamped at column one
      '{6'd2,  CH_LF,  1'b0, 1'b0, '0},
      '{6'd2,  CH_EOF, 1'b0, 1'b0, '0},
      '{6'd2,  CH_FF,  1'b0, 1'b0, '0},
      '{6'd2,  CH_HOM, 1'b1, 1'b0, '0},
      '{6'd2,  CH_ESC, 1'b0, 1'b0, '0},   // escape then an ordinary byte
      '{6'd2,  8'h78,  1'b0, 1'b0, '0},
      '{6'd2,  CH_ESC, 1'b0, 1'b0, '0},   // escape T with zero length
      '{6'd2,  CH_T,   1'b0, 1'b0, '0},
      '{6'd2,  8'h00,  1'b0, 1'b0, '0},
      '{6'd2,  8'h00,  1'b0, 1'b0, '0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Phase one: sender idles a little, receiver a lot.
    send_idle_pct = 16;
    recv_idle_pct = 54;
    foreach (steps[i])
      send_byte(steps[i].ch, steps[i].d, steps[i].f, steps[i].typed, steps[i].want);
    play_random(printer_items + PHASE_ITEMS);

    // Hold the sender until everything has drained.
    in_valid <= 1'b0;
    wait_for_drain();

    // Phase two: the other way round.
    send_idle_pct = 54;
    recv_idle_pct = 16;
    play_random(printer_items + PHASE_ITEMS);
    in_valid <= 1'b0;
    wait_for_drain();

    // Phase three: no idling on either side, items back to back.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    play_random(printer_items + PHASE_ITEMS);

    in_valid <= 1'b0;
    wait_for_drain();
    if (pending_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Run covered %0d items (%0d to printers) and %0d checked results,",
             items_sent, printer_items, results_seen);
    $display("including escapes, raw runs and rejected channels under three idle patterns.");
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
